[hdl/arp_pkg.sv]
package arp_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int ENTRY_W = IP_W + MAC_W;
    localparam int CFG_W   = 48;

    // command codes
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_PACKET = 2'd2;

    // configuration register indexes
    localparam logic CFG_OWN_IP  = 1'b0;
    localparam logic CFG_OWN_MAC = 1'b1;

    // arp header checks
    localparam logic [15:0] MIN_FRAME  = 16'd42;
    localparam logic [15:0] HW_ETHER   = 16'd1;
    localparam logic [15:0] PROTO_IPV4 = 16'h0800;
    localparam logic [7:0]  MAC_BYTES  = 8'd6;
    localparam logic [7:0]  IP_BYTES   = 8'd4;
    localparam logic [15:0] OP_REQUEST = 16'd1;

endpackage

[hdl/arp_cache_responder.sv]
// sequence: a rejected packet or an unused command goes from idle straight to the
//   finish step; otherwise each entry scanned (up to 16) takes a read state and a
//   compare state on the single table read port and the shared 32-bit comparator
// intake: a new beat is taken only back in idle, after the finish step has issued
// reset: rst_n asynchronous active low clears valid bits, count, registers
module arp_cache_responder (
    input  logic                           clk,
    input  logic                           rst_n,

    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     command,
    input  logic [arp_pkg::IP_W-1:0]       ip_addr,
    input  logic [arp_pkg::MAC_W-1:0]      mac_addr,
    input  logic [arp_pkg::IP_W-1:0]       tgt_ip,
    input  logic [15:0]                    opcode,
    input  logic [15:0]                    hw_type,
    input  logic [15:0]                    ptype,
    input  logic [7:0]                     hw_len,
    input  logic [7:0]                     plen,
    input  logic [15:0]                    frame_length,

    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           status,
    output logic                           found,
    output logic [arp_pkg::MAC_W-1:0]      mac_out,
    output logic                           send_reply,
    output logic [arp_pkg::MAC_W-1:0]      reply_target_mac,
    output logic [arp_pkg::IP_W-1:0]       reply_target_ip,

    // configuration write port
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [arp_pkg::CFG_W-1:0]      cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_FINISH
    } state_t;

    localparam logic [arp_pkg::IDX_W-1:0] LAST_IDX =
        arp_pkg::IDX_W'(arp_pkg::TABLE_ENTRIES - 1);

    // configuration
    logic [arp_pkg::IP_W-1:0]  own_ip_reg;
    logic [arp_pkg::MAC_W-1:0] own_mac_reg;

    // sequencer state and latched item
    state_t                        state_reg, state_next;
    logic [arp_pkg::IP_W-1:0]      key_reg, key_next;
    logic [arp_pkg::MAC_W-1:0]     mac_reg, mac_next;
    logic [arp_pkg::IP_W-1:0]      tip_reg, tip_next;
    logic [15:0]                   op_reg, op_next;
    logic                          lookup_reg, lookup_next;
    logic                          learn_reg, learn_next;
    logic                          pkt_ok_reg, pkt_ok_next;
    logic                          reject_reg, reject_next;

    // scan bookkeeping
    logic [arp_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                          hit_reg, hit_next;
    logic [arp_pkg::MAC_W-1:0]     hit_mac_reg, hit_mac_next;
    logic                          free_found_reg, free_found_next;
    logic [arp_pkg::IDX_W-1:0]     free_idx_reg, free_idx_next;

    // table state outside the ram
    logic [arp_pkg::TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [arp_pkg::CNT_W-1:0]         count_reg, count_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic                          status_reg, status_next;
    logic                          found_reg, found_next;
    logic [arp_pkg::MAC_W-1:0]     mac_out_reg, mac_out_next;
    logic                          reply_reg, reply_next;
    logic [arp_pkg::MAC_W-1:0]     reply_mac_reg, reply_mac_next;
    logic [arp_pkg::IP_W-1:0]      reply_ip_reg, reply_ip_next;

    // table ram
    logic                          ram_we;
    logic [arp_pkg::IDX_W-1:0]     ram_waddr;
    logic                          ram_re;
    logic [arp_pkg::ENTRY_W-1:0]   ram_rdata;
    logic [arp_pkg::IP_W-1:0]      rd_ip;
    logic [arp_pkg::MAC_W-1:0]     rd_mac;

    // shared comparator
    logic [arp_pkg::IP_W-1:0]      cmp_a;
    logic [arp_pkg::IP_W-1:0]      cmp_b;
    logic                          cmp_eq;

    logic                          hdr_ok;
    logic                          slot_valid;
    logic                          out_free;

    arp_ram #(
        .WIDTH (arp_pkg::ENTRY_W),
        .DEPTH (arp_pkg::TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({key_reg, mac_reg}),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_ip  = ram_rdata[arp_pkg::ENTRY_W-1:arp_pkg::MAC_W];
    assign rd_mac = ram_rdata[arp_pkg::MAC_W-1:0];

    // one comparator: entry ip against the key while scanning,
    // own ip against the target ip when the result is built
    assign cmp_a  = (state_reg == S_CMP) ? rd_ip   : own_ip_reg;
    assign cmp_b  = (state_reg == S_CMP) ? key_reg : tip_reg;
    assign cmp_eq = (cmp_a == cmp_b);

    // arp header sanity for a received packet
    assign hdr_ok = (frame_length >= arp_pkg::MIN_FRAME) &&
                    (hw_type == arp_pkg::HW_ETHER) &&
                    (ptype == arp_pkg::PROTO_IPV4) &&
                    (hw_len == arp_pkg::MAC_BYTES) &&
                    (plen == arp_pkg::IP_BYTES);

    assign slot_valid = valid_reg[idx_reg];
    assign out_free   = !out_valid_reg || !out_stall;

    // new beats only when the sequencer is idle
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        mac_next        = mac_reg;
        tip_next        = tip_reg;
        op_next         = op_reg;
        lookup_next     = lookup_reg;
        learn_next      = learn_reg;
        pkt_ok_next     = pkt_ok_reg;
        reject_next     = reject_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        hit_mac_next    = hit_mac_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        mac_out_next    = mac_out_reg;
        reply_next      = reply_reg;
        reply_mac_next  = reply_mac_reg;
        reply_ip_next   = reply_ip_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_re          = 1'b0;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next        = ip_addr;
                    mac_next        = mac_addr;
                    tip_next        = tgt_ip;
                    op_next         = opcode;
                    lookup_next     = (command == arp_pkg::CMD_LOOKUP);
                    pkt_ok_next     = (command == arp_pkg::CMD_PACKET) && hdr_ok;
                    reject_next     = (command == arp_pkg::CMD_PACKET) && !hdr_ok;
                    learn_next      = (command == arp_pkg::CMD_INSERT) ||
                                      ((command == arp_pkg::CMD_PACKET) && hdr_ok);
                    idx_next        = '0;
                    hit_next        = 1'b0;
                    hit_mac_next    = '0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    if ((command == arp_pkg::CMD_LOOKUP) ||
                        (command == arp_pkg::CMD_INSERT) ||
                        ((command == arp_pkg::CMD_PACKET) && hdr_ok))
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (slot_valid && cmp_eq)
                begin
                    // first valid match ends the scan, idx stays on it
                    hit_next     = 1'b1;
                    hit_mac_next = rd_mac;
                    state_next   = S_FINISH;
                end
                else
                begin
                    if (!slot_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    // matching slot, else first free slot, else slot 0
                    if (hit_reg)
                    begin
                        ram_waddr = idx_reg;
                    end
                    else if (free_found_reg)
                    begin
                        ram_waddr = free_idx_reg;
                    end
                    else
                    begin
                        ram_waddr = '0;
                    end
                    ram_we = learn_reg;
                    if (learn_reg)
                    begin
                        valid_next[ram_waddr] = 1'b1;
                        if (!hit_reg && free_found_reg)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end

                    out_valid_next = 1'b1;
                    status_next    = reject_reg;
                    found_next     = lookup_reg && hit_reg;
                    mac_out_next   = (lookup_reg && hit_reg) ? hit_mac_reg : '0;
                    reply_next     = pkt_ok_reg && (op_reg == arp_pkg::OP_REQUEST) &&
                                     (own_ip_reg != '0) && cmp_eq;
                    reply_mac_next = reply_next ? mac_reg : '0;
                    reply_ip_next  = reply_next ? key_reg : '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            key_reg        <= '0;
            mac_reg        <= '0;
            tip_reg        <= '0;
            op_reg         <= '0;
            lookup_reg     <= 1'b0;
            learn_reg      <= 1'b0;
            pkt_ok_reg     <= 1'b0;
            reject_reg     <= 1'b0;
            idx_reg        <= '0;
            hit_reg        <= 1'b0;
            hit_mac_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            valid_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= 1'b0;
            found_reg      <= 1'b0;
            mac_out_reg    <= '0;
            reply_reg      <= 1'b0;
            reply_mac_reg  <= '0;
            reply_ip_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            key_reg        <= key_next;
            mac_reg        <= mac_next;
            tip_reg        <= tip_next;
            op_reg         <= op_next;
            lookup_reg     <= lookup_next;
            learn_reg      <= learn_next;
            pkt_ok_reg     <= pkt_ok_next;
            reject_reg     <= reject_next;
            idx_reg        <= idx_next;
            hit_reg        <= hit_next;
            hit_mac_reg    <= hit_mac_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            found_reg      <= found_next;
            mac_out_reg    <= mac_out_next;
            reply_reg      <= reply_next;
            reply_mac_reg  <= reply_mac_next;
            reply_ip_reg   <= reply_ip_next;
        end
    end

    // configuration writes, unknown indexes cannot occur with a one-bit index
    // own mac is written here but is not read by the sequencer or driven to a port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                arp_pkg::CFG_OWN_IP:  own_ip_reg  <= cfg_data[arp_pkg::IP_W-1:0];
                arp_pkg::CFG_OWN_MAC: own_mac_reg <= cfg_data[arp_pkg::MAC_W-1:0];
                default:              own_ip_reg  <= own_ip_reg;
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign found            = found_reg;
    assign mac_out          = mac_out_reg;
    assign send_reply       = reply_reg;
    assign reply_target_mac = reply_mac_reg;
    assign reply_target_ip  = reply_ip_reg;

`ifndef SYNTH
    // occupancy count tracks the number of valid slots
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == arp_pkg::CNT_W'($countones(valid_reg)))
        else $error("occupancy count out of step with valid bits");

    // a result only appears out of the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_FINISH))
        else $error("result beat without finish step");

    // a lookup hit never comes with a reject or a reply
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (!status && !send_reply))
        else $error("lookup hit mixed with packet result");

    // table writes only at the finish step, and a valid slot stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_FINISH) &&
                    ((valid_next & valid_reg) == valid_reg)))
        else $error("table write outside finish step");
`endif

endmodule

[hdl/arp_ram.sv]
module arp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
